/* sv/tcf_pkg.sv */
// ============================================================================
// tcf_pkg : shared constants, types and tables of the tilt filter
// Fixed widths, sequencing counts and the CORDIC arctangent table.
// ============================================================================
package tcf_pkg;

    // Calibration length and CORDIC depth
    localparam int CAL_SAMPLES  = 100;
    localparam int CAL_W        = 7;
    localparam int CORDIC_STEPS = 16;
    localparam int CRD_IDX_W    = $clog2(CORDIC_STEPS);

    // Square-root unit: 64-bit radicand, 32-bit root
    localparam int SQ_OP_W  = 64;
    localparam int ROOT_W   = 32;
    localparam int SQ_CNT_W = $clog2(ROOT_W);

    // CORDIC datapath widths
    localparam int CRD_W = 36;
    localparam int ANG_W = 25;

    // Shared multiplier widths
    localparam int MUL_A_W = 40;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Floor division by CAL_SAMPLES: bias to positive, multiply by reciprocal
    localparam int  INC_BIAS   = 1 << 16;
    localparam int  UX_OFFSET  = CAL_SAMPLES * INC_BIAS;
    localparam int  RECIP_SH   = 31;
    localparam longint RECIP   = ((64'd1 << RECIP_SH) + CAL_SAMPLES - 1) / CAL_SAMPLES;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_FILTER_OMEGA = 3'd0,
        CFG_ANGLE_LIMIT  = 3'd1,
        CFG_ACCEL_Z_BIAS = 3'd2,
        CFG_GYRO_GAIN    = 3'd3,
        CFG_TICK_PERIOD  = 3'd4
    } cfg_idx_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic signed [ANG_W-1:0] atan_deg(input logic [4:0] i);
        logic signed [ANG_W-1:0] a;
        case (i)
            5'd0:    a = 25'sd2949120;
            5'd1:    a = 25'sd1740967;
            5'd2:    a = 25'sd919879;
            5'd3:    a = 25'sd466945;
            5'd4:    a = 25'sd234379;
            5'd5:    a = 25'sd117304;
            5'd6:    a = 25'sd58666;
            5'd7:    a = 25'sd29334;
            5'd8:    a = 25'sd14668;
            5'd9:    a = 25'sd7334;
            5'd10:   a = 25'sd3667;
            5'd11:   a = 25'sd1833;
            5'd12:   a = 25'sd917;
            5'd13:   a = 25'sd458;
            5'd14:   a = 25'sd229;
            5'd15:   a = 25'sd115;
            5'd16:   a = 25'sd57;
            5'd17:   a = 25'sd29;
            5'd18:   a = 25'sd14;
            5'd19:   a = 25'sd7;
            5'd20:   a = 25'sd4;
            5'd21:   a = 25'sd2;
            5'd22:   a = 25'sd1;
            default: a = 25'sd0;
        endcase
        return a;
    endfunction

endpackage

/* sv/tcf_mul.sv */
// ============================================================================
// tcf_mul : shared signed multiplier
// One registered signed product; the sequencer reuses it for every multiply.
// ============================================================================
module tcf_mul (
    input  logic                                 aclk,
    input  logic signed [tcf_pkg::MUL_A_W-1:0]   a,
    input  logic signed [tcf_pkg::MUL_B_W-1:0]   b,
    output logic signed [tcf_pkg::MUL_P_W-1:0]   p
);
    import tcf_pkg::*;

    // product register, valid in the cycle after the operands are applied
    always_ff @(posedge aclk) begin
        p <= MUL_P_W'(a) * MUL_P_W'(b);
    end

endmodule

/* sv/tcf_isqrt.sv */
// ============================================================================
// tcf_isqrt : iterative integer square root
// Restoring digit-by-digit root, one result bit per cycle, floor result.
// ============================================================================
module tcf_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tcf_pkg::SQ_OP_W-1:0]   op,
    output logic                          done,
    output logic [tcf_pkg::ROOT_W-1:0]    root
);
    import tcf_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic [SQ_OP_W-1:0]  op_reg;
    logic [ROOT_W+2:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;

    logic [ROOT_W+2:0]   rem_sh;
    logic [ROOT_W+2:0]   trial;
    logic                fits;

    // next two radicand bits against the trial value
    assign rem_sh = {rem_reg[ROOT_W:0], op_reg[SQ_OP_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                op_reg   <= op;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                op_reg   <= {op_reg[SQ_OP_W-3:0], 2'b00};
                rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], fits};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == SQ_CNT_W'(ROOT_W-1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* sv/tcf_cordic.sv */
// ============================================================================
// tcf_cordic : iterative CORDIC in vectoring mode
// Drives y to zero one micro-rotation per cycle and sums the angle in degrees.
// ============================================================================
module tcf_cordic (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [tcf_pkg::CRD_W-1:0]   x0,
    input  logic signed [tcf_pkg::CRD_W-1:0]   y0,
    output logic                               done,
    output logic signed [tcf_pkg::ANG_W-1:0]   z
);
    import tcf_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [CRD_IDX_W-1:0]    idx_reg;
    logic signed [CRD_W-1:0] x_reg;
    logic signed [CRD_W-1:0] y_reg;
    logic signed [ANG_W-1:0] z_reg;

    logic signed [CRD_W-1:0] xs;
    logic signed [CRD_W-1:0] ys;
    logic signed [ANG_W-1:0] ang;

    assign xs  = x_reg >>> idx_reg;
    assign ys  = y_reg >>> idx_reg;
    assign ang = atan_deg(5'(idx_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg   <= x0;
                y_reg   <= y0;
                z_reg   <= '0;
                idx_reg <= '0;
                // origin vector: angle is zero, finish at once
                if (x0 == '0 && y0 == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                if (!y_reg[CRD_W-1]) begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + ang;
                end else begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - ang;
                end
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == CRD_IDX_W'(CORDIC_STEPS-1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign z    = z_reg;

endmodule

/* sv/tilt_complementary_filter.sv */
// ============================================================================
// tilt_complementary_filter : accelerometer/gyro tilt estimator
// Bias calibration, CORDIC tilt angles and complementary filter with clamp.
// ============================================================================
// The first 100 transfers are calibration samples: each leaves s_tready
// high and gives no result. Every later transfer gives one roll/pitch
// result, and s_tready is low from its acceptance until that result is
// committed. Each result takes two square roots and two CORDIC runs, one
// of each for roll and for pitch, plus thirteen passes through the one
// shared multiplier and a commit. An all-zero accel vector ends both
// CORDIC runs at once with a zero angle. A finished result waits in the
// output register, so the next transfer can start while it is still
// pending; a second result then holds in the done state until the first
// one leaves. Angles are degrees with 16 fraction bits, clamped to
// +-angle_limit.
module tilt_complementary_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // accel_x_raw[9:0], accel_y_raw[19:10], accel_z_raw[29:20],
    // gyro_x_raw[39:30], gyro_y_raw[49:40], elapsed_ticks[57:50], zero pad
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // roll_angle[23:0], pitch_angle[47:24]
    output logic [47:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);
    import tcf_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
        ST_M8, ST_M9, ST_SQRT_R, ST_CORD_R, ST_SQRT_P, ST_CORD_P,
        ST_M10, ST_M11, ST_M12, ST_M13, ST_M14, ST_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [19:0] omega_reg;
    logic [22:0] limit_reg;
    logic [9:0]  zbias_reg;
    logic [19:0] gain_reg;
    logic [23:0] tick_reg;

    // calibration and filter state
    logic [CAL_W-1:0] calib_cnt_reg;
    logic [16:0]      sum_ax_reg, sum_ay_reg, sum_gx_reg, sum_gy_reg;
    logic signed [23:0] roll_reg, pitch_reg;

    // per-item working registers
    logic signed [17:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic [7:0]         ticks_reg;
    logic [34:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [23:0]        dt24_reg;
    logic signed [37:0] gpx_reg, gpy_reg;
    logic [35:0]        wdt_reg;
    logic signed [62:0] nx_reg, ny_reg;
    logic signed [ANG_W-1:0] thx_reg, thy_reg;
    logic signed [33:0] corrx_reg, corry_reg;
    logic signed [17:0] incx_reg, incy_reg;

    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    // input unpacking
    logic [9:0] in_ax, in_ay, in_az, in_gx, in_gy;
    logic [7:0] in_ticks;
    assign in_ax    = s_tdata[9:0];
    assign in_ay    = s_tdata[19:10];
    assign in_az    = s_tdata[29:20];
    assign in_gx    = s_tdata[39:30];
    assign in_gy    = s_tdata[49:40];
    assign in_ticks = s_tdata[57:50];

    logic s_xfer;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    // centered samples, scaled by the calibration count
    logic [16:0] ax_scl, ay_scl, gx_scl, gy_scl;
    logic signed [10:0] dz;
    logic signed [17:0] ax_c, ay_c, az_c, gx_c, gy_c;
    assign ax_scl = 17'(in_ax) * 17'(CAL_SAMPLES);
    assign ay_scl = 17'(in_ay) * 17'(CAL_SAMPLES);
    assign gx_scl = 17'(in_gx) * 17'(CAL_SAMPLES);
    assign gy_scl = 17'(in_gy) * 17'(CAL_SAMPLES);
    assign ax_c   = $signed({1'b0, ax_scl}) - $signed({1'b0, sum_ax_reg});
    assign ay_c   = $signed({1'b0, ay_scl}) - $signed({1'b0, sum_ay_reg});
    assign gx_c   = $signed({1'b0, gx_scl}) - $signed({1'b0, sum_gx_reg});
    assign gy_c   = $signed({1'b0, gy_scl}) - $signed({1'b0, sum_gy_reg});
    assign dz     = $signed({1'b0, in_az}) - $signed({1'b0, zbias_reg});
    assign az_c   = 18'(dz) * 18'(CAL_SAMPLES);

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    tcf_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    // filter error terms and the positive-biased gyro quotients
    logic signed [25:0] diff_x, diff_y;
    logic signed [63:0] nsum_x, nsum_y;
    logic [24:0]        ux_x, ux_y;
    logic signed [MUL_P_W-1:0] rnd;
    assign diff_x = 26'(thx_reg) - 26'(roll_reg);
    assign diff_y = 26'(thy_reg) - 26'(pitch_reg);
    assign nsum_x = 64'(nx_reg) + (64'(CAL_SAMPLES) << 39);
    assign nsum_y = 64'(ny_reg) + (64'(CAL_SAMPLES) << 39);
    assign ux_x   = 25'($signed(nsum_x[63:40])) + 25'(UX_OFFSET);
    assign ux_y   = 25'($signed(nsum_y[63:40])) + 25'(UX_OFFSET);
    assign rnd    = mul_p + (MUL_P_W'(1) << 31);

    // operand selection per sequencer step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_M0:  begin mul_a = 40'(ax_reg);    mul_b = 26'(ax_reg);    end
            ST_M1:  begin mul_a = 40'(ay_reg);    mul_b = 26'(ay_reg);    end
            ST_M2:  begin mul_a = 40'(az_reg);    mul_b = 26'(az_reg);    end
            ST_M3:  begin mul_a = 40'(tick_reg);  mul_b = 26'(ticks_reg); end
            ST_M4:  begin mul_a = 40'(gx_reg);    mul_b = 26'(gain_reg);  end
            ST_M5:  begin mul_a = 40'(gy_reg);    mul_b = 26'(gain_reg);  end
            ST_M6:  begin mul_a = 40'(omega_reg); mul_b = 26'(dt24_reg);  end
            ST_M7:  begin mul_a = 40'(gpx_reg);   mul_b = 26'(dt24_reg);  end
            ST_M8:  begin mul_a = 40'(gpy_reg);   mul_b = 26'(dt24_reg);  end
            ST_M10: begin mul_a = 40'(wdt_reg);   mul_b = diff_x;         end
            ST_M11: begin mul_a = 40'(wdt_reg);   mul_b = diff_y;         end
            ST_M12: begin mul_a = 40'(ux_x);      mul_b = 26'(RECIP);     end
            ST_M13: begin mul_a = 40'(ux_y);      mul_b = 26'(RECIP);     end
            default: begin mul_a = '0;            mul_b = '0;             end
        endcase
    end

    // square root and CORDIC, run for roll then pitch
    logic              sqrt_start, sqrt_done;
    logic [35:0]       sqrt_sum;
    logic [ROOT_W-1:0] sqrt_root;
    logic              crd_start, crd_done;
    logic signed [CRD_W-1:0] crd_y0;
    logic signed [ANG_W-1:0] crd_z;

    assign sqrt_start = (state_reg == ST_M9) || (state_reg == ST_CORD_R && crd_done);
    assign sqrt_sum   = (state_reg == ST_CORD_R) ? (36'(sqx_reg) + 36'(sqz_reg))
                                                 : (36'(sqy_reg) + 36'(sqz_reg));
    assign crd_start  = (state_reg == ST_SQRT_R || state_reg == ST_SQRT_P) && sqrt_done;
    assign crd_y0     = (state_reg == ST_SQRT_P)
                      ? $signed({{4{ay_reg[17]}}, ay_reg, 14'd0})
                      : $signed({{4{ax_reg[17]}}, ax_reg, 14'd0});

    tcf_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .op      ({sqrt_sum, 28'd0}),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    tcf_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (crd_start),
        .x0      ($signed({4'd0, sqrt_root})),
        .y0      (crd_y0),
        .done    (crd_done),
        .z       (crd_z)
    );

    // state update with clamp
    logic signed [35:0] lim36, vx, vy, nroll, npitch;
    assign lim36  = $signed(36'(limit_reg));
    assign vx     = 36'(roll_reg) + 36'(incx_reg) + 36'(corrx_reg);
    assign vy     = 36'(pitch_reg) + 36'(incy_reg) + 36'(corry_reg);
    assign nroll  = (vx > lim36) ? lim36 : ((vx < -lim36) ? -lim36 : vx);
    assign npitch = (vy > lim36) ? lim36 : ((vy < -lim36) ? -lim36 : vy);

    // result commit: done state and output register free
    logic commit;
    assign commit = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // sequencer, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            omega_reg     <= 20'd152357;
            limit_reg     <= 23'd1179648;
            zbias_reg     <= 10'd507;
            gain_reg      <= 20'd140538;
            tick_reg      <= 24'd549756;
            calib_cnt_reg <= '0;
            sum_ax_reg    <= '0;
            sum_ay_reg    <= '0;
            sum_gx_reg    <= '0;
            sum_gy_reg    <= '0;
            roll_reg      <= '0;
            pitch_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_FILTER_OMEGA: omega_reg <= cfg_wdata[19:0];
                    CFG_ANGLE_LIMIT:  limit_reg <= cfg_wdata[22:0];
                    CFG_ACCEL_Z_BIAS: zbias_reg <= cfg_wdata[9:0];
                    CFG_GYRO_GAIN:    gain_reg  <= cfg_wdata[19:0];
                    CFG_TICK_PERIOD:  tick_reg  <= cfg_wdata;
                    default: ;
                endcase
            end

            // output valid: set on commit, cleared when taken
            if (commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        if (calib_cnt_reg < CAL_W'(CAL_SAMPLES)) begin
                            sum_ax_reg    <= sum_ax_reg + 17'(in_ax);
                            sum_ay_reg    <= sum_ay_reg + 17'(in_ay);
                            sum_gx_reg    <= sum_gx_reg + 17'(in_gx);
                            sum_gy_reg    <= sum_gy_reg + 17'(in_gy);
                            calib_cnt_reg <= calib_cnt_reg + 1'b1;
                        end else begin
                            ax_reg    <= ax_c;
                            ay_reg    <= ay_c;
                            az_reg    <= az_c;
                            gx_reg    <= gx_c;
                            gy_reg    <= gy_c;
                            ticks_reg <= in_ticks;
                            state_reg <= ST_M0;
                        end
                    end
                end
                ST_M0: state_reg <= ST_M1;
                ST_M1: begin sqx_reg <= mul_p[34:0];  state_reg <= ST_M2; end
                ST_M2: begin sqy_reg <= mul_p[34:0];  state_reg <= ST_M3; end
                ST_M3: begin sqz_reg <= mul_p[34:0];  state_reg <= ST_M4; end
                ST_M4: begin dt24_reg <= mul_p[31:8]; state_reg <= ST_M5; end
                ST_M5: begin gpx_reg <= mul_p[37:0];  state_reg <= ST_M6; end
                ST_M6: begin gpy_reg <= mul_p[37:0];  state_reg <= ST_M7; end
                ST_M7: begin wdt_reg <= mul_p[43:8];  state_reg <= ST_M8; end
                ST_M8: begin nx_reg <= mul_p[62:0];   state_reg <= ST_M9; end
                ST_M9: begin ny_reg <= mul_p[62:0];   state_reg <= ST_SQRT_R; end
                ST_SQRT_R: begin
                    if (sqrt_done) state_reg <= ST_CORD_R;
                end
                ST_CORD_R: begin
                    if (crd_done) begin
                        thx_reg   <= crd_z;
                        state_reg <= ST_SQRT_P;
                    end
                end
                ST_SQRT_P: begin
                    if (sqrt_done) state_reg <= ST_CORD_P;
                end
                ST_CORD_P: begin
                    if (crd_done) begin
                        thy_reg   <= crd_z;
                        state_reg <= ST_M10;
                    end
                end
                ST_M10: state_reg <= ST_M11;
                ST_M11: begin corrx_reg <= rnd[65:32]; state_reg <= ST_M12; end
                ST_M12: begin corry_reg <= rnd[65:32]; state_reg <= ST_M13; end
                ST_M13: begin
                    incx_reg  <= 18'({1'b0, mul_p[48:31]} - 19'(INC_BIAS));
                    state_reg <= ST_M14;
                end
                ST_M14: begin
                    incy_reg  <= 18'({1'b0, mul_p[48:31]} - 19'(INC_BIAS));
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    // commit once the output register is free
                    if (commit) begin
                        roll_reg     <= 24'(nroll);
                        pitch_reg    <= 24'(npitch);
                        m_tdata_reg  <= {24'(npitch), 24'(nroll)};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // calibration counter stops at its limit
    a_calib_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        calib_cnt_reg <= CAL_W'(CAL_SAMPLES))
        else $error("calibration count past limit");

    // root arrives only while the sequencer waits for it
    a_sqrt_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_done |-> (state_reg == ST_SQRT_R || state_reg == ST_SQRT_P))
        else $error("square root done outside wait state");

    // angle arrives only while the sequencer waits for it
    a_cordic_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        crd_done |-> (state_reg == ST_CORD_R || state_reg == ST_CORD_P))
        else $error("CORDIC done outside wait state");

    // a post-calibration transfer starts the sequence
    a_start_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && calib_cnt_reg == CAL_W'(CAL_SAMPLES)) |=> (state_reg == ST_M0))
        else $error("sequence did not start");

endmodule
